### rtl/hppe_pkg.sv
// ----------------------------------------------------------------------------
// hppe_pkg
// Shared types and constants of the hi-res pixel plot engine.
// ----------------------------------------------------------------------------
package hppe_pkg;

   localparam int OFFSET_W = 13;

   localparam logic [1:0] CMD_PLOT    = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_PALETTE = 2'd2;
   localparam logic [1:0] CMD_SEAM    = 2'd3;

   localparam logic [2:0] COLOR_BLACK  = 3'd0;
   localparam logic [2:0] COLOR_WHITE  = 3'd1;
   localparam logic [2:0] COLOR_VIOLET = 3'd2;
   localparam logic [2:0] COLOR_GREEN  = 3'd3;
   localparam logic [2:0] COLOR_BLUE   = 3'd4;
   localparam logic [2:0] COLOR_ORANGE = 3'd5;

   localparam logic [1:0] PAL_CLEAR = 2'd0;
   localparam logic [1:0] PAL_SET   = 2'd1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_SAME  = 2'd2;

   localparam logic [8:0] MAX_X        = 9'd279;
   localparam logic [7:0] MAX_Y        = 8'd191;
   localparam logic [5:0] MAX_BYTE_COL = 6'd39;
   localparam logic [5:0] MAX_SEAM_COL = 6'd38;

   // x / 7 as (x * 293) >> 11, exact for x below 512
   localparam logic [17:0] DIV7_MUL   = 18'd293;
   localparam int          DIV7_SHIFT = 11;

   localparam logic [OFFSET_W-1:0] GROUP_STRIDE = 13'h028;

   localparam logic [7:0] PIXEL_MASK   = 8'h7F;
   localparam logic [7:0] PALETTE_MASK = 8'h80;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_EXEC
   } back_state_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic                bad;
      logic [OFFSET_W-1:0] addr_a;
      logic [OFFSET_W-1:0] addr_b;
      logic [2:0]          bit_idx;
      logic                x_odd;
      logic                x_first;
      logic                x_last;
      logic [2:0]          color;
      logic [1:0]          pal_mode;
   } entry_type;

endpackage

### rtl/hppe_front.sv
// ----------------------------------------------------------------------------
// hppe_front
// Request intake: range checks, color column snap and page address decode.
// ----------------------------------------------------------------------------
module hppe_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [8:0]            req_x,
   input  logic [7:0]            req_y,
   input  logic [2:0]            req_color,
   input  logic [5:0]            req_byte_col,
   input  logic [1:0]            req_palette_mode,
   input  logic                  q_full,
   input  logic                  clear_busy,
   output logic                  push,
   output hppe_pkg::entry_type   push_data
);

   logic        chroma;
   logic        want_odd;
   logic        snap;
   logic [8:0]  sx;
   logic [17:0] prod;
   logic [5:0]  q;
   logic [8:0]  rem;
   logic [5:0]  col;
   logic [hppe_pkg::OFFSET_W-1:0] base;
   logic [hppe_pkg::OFFSET_W-1:0] addr_a;
   logic        y_ok;
   logic        x_ok;
   logic        bad;

   assign req_ready = !q_full && !clear_busy;
   assign push      = req_valid && req_ready;

   always_comb begin
      chroma   = (req_color inside {[hppe_pkg::COLOR_VIOLET:hppe_pkg::COLOR_ORANGE]});
      want_odd = (req_color == hppe_pkg::COLOR_GREEN) || (req_color == hppe_pkg::COLOR_ORANGE);
      snap     = (req_cmd == hppe_pkg::CMD_PLOT) && chroma && (req_x[0] != want_odd);
      if (snap) begin
         sx = (req_x != 9'd0) ? req_x - 9'd1 : req_x + 9'd1;
      end else begin
         sx = req_x;
      end
      prod = 18'(sx) * hppe_pkg::DIV7_MUL;
      q    = prod[hppe_pkg::DIV7_SHIFT +: 6];
      rem  = sx - ({q, 3'b000} - {3'b000, q});
      base = 13'(req_y[7:6]) * hppe_pkg::GROUP_STRIDE
           + {3'b000, req_y[5:3], 7'b0000000}
           + {req_y[2:0], 10'b0000000000};
      col    = req_cmd[1] ? req_byte_col : q;
      addr_a = base + 13'(col);

      y_ok = req_y <= hppe_pkg::MAX_Y;
      x_ok = req_x <= hppe_pkg::MAX_X;
      case (req_cmd)
         hppe_pkg::CMD_PLOT:    bad = !(x_ok && y_ok && req_color <= hppe_pkg::COLOR_ORANGE);
         hppe_pkg::CMD_READ:    bad = !(x_ok && y_ok);
         hppe_pkg::CMD_PALETTE: bad = !(y_ok && req_byte_col <= hppe_pkg::MAX_BYTE_COL);
         default:               bad = !(y_ok && req_byte_col <= hppe_pkg::MAX_SEAM_COL);
      endcase

      push_data.cmd     = req_cmd;
      push_data.bad     = bad;
      push_data.addr_a  = addr_a;
      if (req_cmd == hppe_pkg::CMD_READ && rem[2:0] == 3'd0) begin
         push_data.addr_b = addr_a - 13'd1;
      end else begin
         push_data.addr_b = addr_a + 13'd1;
      end
      push_data.bit_idx  = rem[2:0];
      push_data.x_odd    = req_x[0];
      push_data.x_first  = req_x == 9'd0;
      push_data.x_last   = req_x == hppe_pkg::MAX_X;
      push_data.color    = req_color;
      push_data.pal_mode = req_palette_mode;
   end

endmodule

### rtl/hppe_queue.sv
// ----------------------------------------------------------------------------
// hppe_queue
// Two-entry queue between request decode and page execution.
// ----------------------------------------------------------------------------
module hppe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hppe_pkg::entry_type push_data,
   input  logic                pop,
   output hppe_pkg::entry_type head,
   output logic                head_valid,
   output logic                full
);

   localparam int PTR_W = $clog2(hppe_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(hppe_pkg::QUEUE_DEPTH + 1);

   hppe_pkg::entry_type slot_ff [hppe_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign full       = count_ff == CNT_W'(hppe_pkg::QUEUE_DEPTH);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/hppe_back.sv
// ----------------------------------------------------------------------------
// hppe_back
// Page memory, clear sweep after reset, read then modify-write execution
// and the response register.
// ----------------------------------------------------------------------------
module hppe_back #(
   parameter int PAGE_BYTES = 8192
) (
   input  logic                clock,
   input  logic                reset,
   input  hppe_pkg::entry_type head,
   input  logic                head_valid,
   output logic                pop,
   output logic                clear_busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [12:0]         rsp_offset,
   output logic [2:0]          rsp_color_found,
   output logic                rsp_seam
);

   localparam int AW = $clog2(PAGE_BYTES);

   logic [7:0] mem [PAGE_BYTES];

   hppe_pkg::back_state_type state_ff;
   hppe_pkg::back_state_type state_in;
   logic [AW-1:0] clr_cnt_ff;
   logic [AW-1:0] clr_cnt_in;
   logic [7:0]    rd_a_ff;
   logic [7:0]    rd_b_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [1:0]    status_ff;
   logic [12:0]   offset_ff;
   logic [2:0]    found_ff;
   logic          seam_ff;

   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          out_free;

   logic [7:0]  mask;
   logic [7:0]  nb;
   logic        modify;
   logic        changed;
   logic        lit;
   logic        left_lit;
   logic        right_lit;
   logic [2:0]  found;
   logic        seam;
   logic [1:0]  status;
   logic [12:0] offset;

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_offset      = offset_ff;
   assign rsp_color_found = found_ff;
   assign rsp_seam        = seam_ff;

   always_comb begin
      mask = 8'd1 << head.bit_idx;
      nb   = rd_a_ff;
      case (head.cmd)
         hppe_pkg::CMD_PLOT: begin
            if (head.color == hppe_pkg::COLOR_BLACK) begin
               nb = rd_a_ff & ~mask;
            end else begin
               if (head.color == hppe_pkg::COLOR_BLUE || head.color == hppe_pkg::COLOR_ORANGE) begin
                  nb = rd_a_ff | hppe_pkg::PALETTE_MASK;
               end else if (head.color != hppe_pkg::COLOR_WHITE) begin
                  nb = rd_a_ff & hppe_pkg::PIXEL_MASK;
               end
               nb = nb | mask;
            end
         end
         hppe_pkg::CMD_PALETTE: begin
            case (head.pal_mode)
               hppe_pkg::PAL_CLEAR: nb = rd_a_ff & hppe_pkg::PIXEL_MASK;
               hppe_pkg::PAL_SET:   nb = rd_a_ff | hppe_pkg::PALETTE_MASK;
               default:             nb = rd_a_ff ^ hppe_pkg::PALETTE_MASK;
            endcase
         end
         default: nb = rd_a_ff;
      endcase
      modify  = (head.cmd == hppe_pkg::CMD_PLOT) || (head.cmd == hppe_pkg::CMD_PALETTE);
      changed = nb != rd_a_ff;

      lit = rd_a_ff[head.bit_idx];
      if (head.bit_idx != 3'd0) begin
         left_lit = rd_a_ff[3'(head.bit_idx - 3'd1)];
      end else begin
         left_lit = !head.x_first && rd_b_ff[6];
      end
      if (head.bit_idx != 3'd6) begin
         right_lit = rd_a_ff[3'(head.bit_idx + 3'd1)];
      end else begin
         right_lit = !head.x_last && rd_b_ff[0];
      end
      if (!lit) begin
         found = hppe_pkg::COLOR_BLACK;
      end else if (left_lit && right_lit) begin
         found = hppe_pkg::COLOR_WHITE;
      end else if (rd_a_ff[7]) begin
         found = head.x_odd ? hppe_pkg::COLOR_ORANGE : hppe_pkg::COLOR_BLUE;
      end else begin
         found = head.x_odd ? hppe_pkg::COLOR_GREEN : hppe_pkg::COLOR_VIOLET;
      end
      seam = (|rd_a_ff[6:0]) && (|rd_b_ff[6:0]) && (rd_a_ff[7] != rd_b_ff[7]);

      status = hppe_pkg::STATUS_OK;
      offset = '0;
      if (head.bad) begin
         status = hppe_pkg::STATUS_RANGE;
         found  = hppe_pkg::COLOR_BLACK;
         seam   = 1'b0;
      end else if (modify && !changed) begin
         status = hppe_pkg::STATUS_SAME;
      end else if (modify) begin
         offset = head.addr_a;
      end
      if (head.cmd != hppe_pkg::CMD_READ) begin
         found = hppe_pkg::COLOR_BLACK;
      end
      if (head.cmd != hppe_pkg::CMD_SEAM) begin
         seam = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = AW'(head.addr_a);
      wr_data      = nb;
      pop          = 1'b0;
      clear_busy   = 1'b0;
      case (state_ff)
         hppe_pkg::BACK_CLEAR: begin
            clear_busy = 1'b1;
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = 8'h00;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(PAGE_BYTES - 1)) begin
               state_in = hppe_pkg::BACK_IDLE;
            end
         end
         hppe_pkg::BACK_IDLE: begin
            if (head_valid) begin
               rd_en    = !head.bad;
               state_in = hppe_pkg::BACK_EXEC;
            end
         end
         hppe_pkg::BACK_EXEC: begin
            if (out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               wr_en        = !head.bad && modify && changed;
               state_in     = hppe_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = hppe_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hppe_pkg::BACK_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status;
         offset_ff <= offset;
         found_ff  <= found;
         seam_ff   <= seam;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[AW'(head.addr_a)];
         rd_b_ff <= mem[AW'(head.addr_b)];
      end
   end

`ifndef SYNTHESIS
   a_write_when_owned: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == hppe_pkg::BACK_EXEC || state_ff == hppe_pkg::BACK_CLEAR))
      else $error("page write outside execute or clear");

   a_pop_needs_slot: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == hppe_pkg::BACK_EXEC && out_free && head_valid))
      else $error("pop without free response slot");

   a_pop_then_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == hppe_pkg::BACK_IDLE && rsp_valid_ff))
      else $error("response not presented after pop");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == hppe_pkg::BACK_CLEAR |-> !rsp_valid_ff)
      else $error("response during clear sweep");
`endif

endmodule

### rtl/hires_pixel_plot_engine_top.sv
// Flow: an accepted request is read from the page in the idle state, then
// updated and answered in the execute state once the response slot is free.
// The back end takes one request at a time: the read and then the modify-write
// of the single page RAM (two read ports, one write port). Reset: synchronous;
// afterwards a sweep zeroes the page, with req_ready held low until it ends.
// ----------------------------------------------------------------------------
// hires_pixel_plot_engine_top
// Hi-res page plot engine: decode front, request queue, page execution back.
// ----------------------------------------------------------------------------
module hires_pixel_plot_engine_top #(
   parameter int PAGE_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [8:0]  req_x,
   input  logic [7:0]  req_y,
   input  logic [2:0]  req_color,
   input  logic [5:0]  req_byte_col,
   input  logic [1:0]  req_palette_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_offset,
   output logic [2:0]  rsp_color_found,
   output logic        rsp_seam
);

   logic                push;
   hppe_pkg::entry_type push_data;
   logic                pop;
   hppe_pkg::entry_type head;
   logic                head_valid;
   logic                q_full;
   logic                clear_busy;

   hppe_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_color        (req_color),
      .req_byte_col     (req_byte_col),
      .req_palette_mode (req_palette_mode),
      .q_full           (q_full),
      .clear_busy       (clear_busy),
      .push             (push),
      .push_data        (push_data)
   );

   hppe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   hppe_back #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (head_valid),
      .pop             (pop),
      .clear_busy      (clear_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_offset      (rsp_offset),
      .rsp_color_found (rsp_color_found),
      .rsp_seam        (rsp_seam)
   );

endmodule

### tb/hppe_checker.sv
// ----------------------------------------------------------------------------
// hppe_checker
// Tracks every request and response of the hi-res pixel plot engine. It keeps
// its own copy of the page and works out the response of each accepted
// request. Each accepted response is compared, field by field, with the
// oldest pending one.
// ----------------------------------------------------------------------------
module hppe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [8:0]  req_x,
   input  logic [7:0]  req_y,
   input  logic [2:0]  req_color,
   input  logic [5:0]  req_byte_col,
   input  logic [1:0]  req_palette_mode,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [12:0] rsp_offset,
   input  logic [2:0]  rsp_color_found,
   input  logic        rsp_seam,
   output logic        drained,
   output int          mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PAGE_SIZE    = 8192;
   localparam logic [12:0] BLOCK_STRIDE = 13'h080;
   localparam logic [12:0] LINE_STRIDE  = 13'h400;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] offset;
      logic [2:0]  color_found;
      logic        seam;
   } outcome_type;

   logic [7:0]  page_image [PAGE_SIZE];
   outcome_type queued_outcomes [$];
   int          outstanding = 0;

   assign drained = (outstanding == 0);

   function automatic logic [12:0] byte_base(logic [7:0] y);
      return 13'(y / 64) * hppe_pkg::GROUP_STRIDE + 13'((y % 64) / 8) * BLOCK_STRIDE
         + 13'(y % 8) * LINE_STRIDE;
   endfunction

   function automatic logic pixel_lit(int px, logic [7:0] y);
      logic [7:0] b;
      if (px < 0 || px > int'(hppe_pkg::MAX_X)) begin
         return 1'b0;
      end
      b = page_image[byte_base(y) + 13'(px / 7)];
      return b[px % 7];
   endfunction

   function automatic outcome_type commit_byte(logic [12:0] addr, logic [7:0] old_b,
         logic [7:0] new_b);
      outcome_type r;
      r = '0;
      if (new_b == old_b) begin
         r.status = hppe_pkg::STATUS_SAME;
      end else begin
         page_image[addr] = new_b;
         r.status = hppe_pkg::STATUS_OK;
         r.offset = addr;
      end
      return r;
   endfunction

   function automatic outcome_type execute_on_page(logic [1:0] cmd, logic [8:0] x,
         logic [7:0] y, logic [2:0] color, logic [5:0] col, logic [1:0] mode);
      outcome_type r;
      logic [8:0]  px;
      logic [12:0] addr;
      logic [7:0]  old_b, new_b, left_b, right_b;
      r = '0;
      r.status = hppe_pkg::STATUS_RANGE;
      case (cmd)
         hppe_pkg::CMD_PLOT: begin
            if (x <= hppe_pkg::MAX_X && y <= hppe_pkg::MAX_Y &&
                color <= hppe_pkg::COLOR_ORANGE) begin
               px = x;
               if (color >= hppe_pkg::COLOR_VIOLET &&
                   px[0] != (color == hppe_pkg::COLOR_GREEN ||
                             color == hppe_pkg::COLOR_ORANGE)) begin
                  px = (px > 0) ? px - 9'd1 : px + 9'd1;
               end
               addr = byte_base(y) + 13'(px / 7);
               old_b = page_image[addr];
               new_b = old_b;
               if (color == hppe_pkg::COLOR_BLACK) begin
                  new_b[px % 7] = 1'b0;
               end else begin
                  if (color == hppe_pkg::COLOR_BLUE || color == hppe_pkg::COLOR_ORANGE) begin
                     new_b = new_b | hppe_pkg::PALETTE_MASK;
                  end else if (color != hppe_pkg::COLOR_WHITE) begin
                     new_b = new_b & hppe_pkg::PIXEL_MASK;
                  end
                  new_b[px % 7] = 1'b1;
               end
               r = commit_byte(addr, old_b, new_b);
            end
         end
         hppe_pkg::CMD_READ: begin
            if (x <= hppe_pkg::MAX_X && y <= hppe_pkg::MAX_Y) begin
               r.status = hppe_pkg::STATUS_OK;
               if (!pixel_lit(int'(x), y)) begin
                  r.color_found = hppe_pkg::COLOR_BLACK;
               end else if (pixel_lit(int'(x) - 1, y) && pixel_lit(int'(x) + 1, y)) begin
                  r.color_found = hppe_pkg::COLOR_WHITE;
               end else begin
                  old_b = page_image[byte_base(y) + 13'(x / 7)];
                  if (old_b[7]) begin
                     r.color_found = x[0] ? hppe_pkg::COLOR_ORANGE : hppe_pkg::COLOR_BLUE;
                  end else begin
                     r.color_found = x[0] ? hppe_pkg::COLOR_GREEN : hppe_pkg::COLOR_VIOLET;
                  end
               end
            end
         end
         hppe_pkg::CMD_PALETTE: begin
            if (col <= hppe_pkg::MAX_BYTE_COL && y <= hppe_pkg::MAX_Y) begin
               addr = byte_base(y) + 13'(col);
               old_b = page_image[addr];
               new_b = old_b;
               case (mode)
                  hppe_pkg::PAL_CLEAR: new_b[7] = 1'b0;
                  hppe_pkg::PAL_SET:   new_b[7] = 1'b1;
                  default:             new_b[7] = ~old_b[7];
               endcase
               r = commit_byte(addr, old_b, new_b);
            end
         end
         default: begin
            if (col <= hppe_pkg::MAX_SEAM_COL && y <= hppe_pkg::MAX_Y) begin
               addr = byte_base(y) + 13'(col);
               left_b = page_image[addr];
               right_b = page_image[addr + 13'd1];
               r.status = hppe_pkg::STATUS_OK;
               r.seam = (left_b[6:0] != 7'd0) && (right_b[6:0] != 7'd0) &&
                        (left_b[7] != right_b[7]);
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (page_image[i]) page_image[i] = 8'h00;
         queued_outcomes.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (queued_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t ns: response with no request pending, status %0d offset %0d",
                        $time, rsp_status, rsp_offset);
            end else begin
               want = queued_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 16'(want.status), 16'(rsp_status));
               if (rsp_offset !== want.offset)
                  report_mismatch("offset", 16'(want.offset), 16'(rsp_offset));
               if (rsp_color_found !== want.color_found)
                  report_mismatch("color_found", 16'(want.color_found),
                                  16'(rsp_color_found));
               if (rsp_seam !== want.seam)
                  report_mismatch("seam", 16'(want.seam), 16'(rsp_seam));
            end
         end
         if (req_valid && req_ready) begin
            queued_outcomes.push_back(execute_on_page(req_cmd, req_x, req_y, req_color,
                                                      req_byte_col, req_palette_mode));
         end
      end
      outstanding <= queued_outcomes.size();
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the hi-res pixel plot engine: a directed pass over the corner
// cases, then random requests aimed at a few crowded rows and byte windows,
// with bursty requests and a stalling response side. The checker predicts
// and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] PAL_TOGGLE     = 2'd2;
   localparam logic [1:0] PAL_TOGGLE_ALT = 2'd3;
   localparam int         RANDOM_REQS    = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = hppe_pkg::CMD_PLOT;
   logic [8:0]  req_x = '0;
   logic [7:0]  req_y = '0;
   logic [2:0]  req_color = hppe_pkg::COLOR_BLACK;
   logic [5:0]  req_byte_col = '0;
   logic [1:0]  req_palette_mode = hppe_pkg::PAL_CLEAR;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [12:0] rsp_offset;
   logic [2:0]  rsp_color_found;
   logic        rsp_seam;
   logic        drained;
   int          mismatches;

   logic [11:0] stall_phase = '0;
   int          burst_left = 0;
   int          cmd_count [4] = '{0, 0, 0, 0};
   logic [7:0]  hot_rows [4] = '{8'd0, 8'd63, 8'd64, 8'd191};

   always #10 clock = ~clock;

   hires_pixel_plot_engine_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_color        (req_color),
      .req_byte_col     (req_byte_col),
      .req_palette_mode (req_palette_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_offset       (rsp_offset),
      .rsp_color_found  (rsp_color_found),
      .rsp_seam         (rsp_seam)
   );

   hppe_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_color        (req_color),
      .req_byte_col     (req_byte_col),
      .req_palette_mode (req_palette_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_offset       (rsp_offset),
      .rsp_color_found  (rsp_color_found),
      .rsp_seam         (rsp_seam),
      .drained          (drained),
      .mismatches       (mismatches)
   );

   // response side: always ready, coin flip, one in eight, mostly ready
   always @(posedge clock) begin
      stall_phase <= stall_phase + 12'd1;
      case (stall_phase[11:10])
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= ($urandom_range(0, 1) == 0);
         2'd2:    rsp_ready <= (stall_phase[2:0] == 3'd0);
         default: rsp_ready <= ($urandom_range(0, 9) < 8);
      endcase
   end

   task automatic send_req(logic [1:0] cmd, logic [8:0] x, logic [7:0] y,
         logic [2:0] color, logic [5:0] col, logic [1:0] mode);
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_x <= x;
      req_y <= y;
      req_color <= color;
      req_byte_col <= col;
      req_palette_mode <= mode;
      do @(posedge clock); while (!req_ready);
      cmd_count[cmd]++;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (!drained);
   endtask

   task automatic send_random_req();
      int          kind;
      logic [1:0]  cmd;
      logic [8:0]  x;
      logic [7:0]  y;
      logic [2:0]  color;
      logic [5:0]  col;
      kind = $urandom_range(0, 99);
      cmd = (kind < 40) ? hppe_pkg::CMD_PLOT : (kind < 65) ? hppe_pkg::CMD_READ :
            (kind < 80) ? hppe_pkg::CMD_PALETTE : hppe_pkg::CMD_SEAM;
      if ($urandom_range(0, 19) == 0) begin
         x = 9'($urandom_range(280, 511));
      end else begin
         case ($urandom_range(0, 2))
            0:       x = 9'($urandom_range(0, 27));
            1:       x = 9'($urandom_range(252, 279));
            default: x = 9'($urandom_range(0, 279));
         endcase
      end
      if ($urandom_range(0, 19) == 0) begin
         y = 8'($urandom_range(192, 255));
      end else if ($urandom_range(0, 1) == 0) begin
         y = hot_rows[$urandom_range(0, 3)];
      end else begin
         y = 8'($urandom_range(0, 191));
      end
      color = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 9) == 0) begin
         col = 6'($urandom_range(40, 63));
      end else if ($urandom_range(0, 1) == 0) begin
         col = 6'($urandom_range(0, 3));
      end else begin
         col = 6'($urandom_range(0, 39));
      end
      send_req(cmd, x, y, color, col, 2'($urandom_range(0, 3)));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // pixel plot, snapping and read-back corners
      send_req(hppe_pkg::CMD_PLOT, 9'd0, 8'd0, hppe_pkg::COLOR_WHITE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd0, 8'd0, hppe_pkg::COLOR_WHITE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_READ, 9'd0, 8'd0, 3'd7, 6'd0, hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd1, 8'd0, hppe_pkg::COLOR_VIOLET, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd0, 8'd191, hppe_pkg::COLOR_GREEN, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd279, 8'd191, hppe_pkg::COLOR_BLUE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd279, 8'd191, hppe_pkg::COLOR_ORANGE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd277, 8'd191, hppe_pkg::COLOR_WHITE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_READ, 9'd278, 8'd191, hppe_pkg::COLOR_BLACK, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_READ, 9'd279, 8'd191, hppe_pkg::COLOR_BLACK, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd279, 8'd191, hppe_pkg::COLOR_BLACK, 6'd0,
               hppe_pkg::PAL_CLEAR);
      // seam across bytes 0 and 1, then at byte columns 38 and 39 of row 191
      send_req(hppe_pkg::CMD_PLOT, 9'd7, 8'd0, hppe_pkg::COLOR_ORANGE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_SEAM, 9'd0, 8'd0, hppe_pkg::COLOR_BLACK, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_SEAM, 9'd0, 8'd191, hppe_pkg::COLOR_BLACK, 6'd38,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_SEAM, 9'd0, 8'd191, hppe_pkg::COLOR_BLACK, 6'd39,
               hppe_pkg::PAL_CLEAR);
      // palette bit actions
      send_req(hppe_pkg::CMD_PALETTE, 9'd0, 8'd191, hppe_pkg::COLOR_BLACK, 6'd39,
               hppe_pkg::PAL_SET);
      send_req(hppe_pkg::CMD_PALETTE, 9'd0, 8'd191, hppe_pkg::COLOR_BLACK, 6'd39,
               hppe_pkg::PAL_SET);
      send_req(hppe_pkg::CMD_PALETTE, 9'd0, 8'd191, hppe_pkg::COLOR_BLACK, 6'd39,
               PAL_TOGGLE_ALT);
      send_req(hppe_pkg::CMD_PALETTE, 9'd0, 8'd191, hppe_pkg::COLOR_BLACK, 6'd39,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PALETTE, 9'd0, 8'd191, hppe_pkg::COLOR_BLACK, 6'd39,
               PAL_TOGGLE);
      send_req(hppe_pkg::CMD_PALETTE, 9'd0, 8'd0, hppe_pkg::COLOR_BLACK, 6'd40,
               hppe_pkg::PAL_SET);
      // out of range
      send_req(hppe_pkg::CMD_PLOT, 9'd280, 8'd0, hppe_pkg::COLOR_WHITE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd0, 8'd192, hppe_pkg::COLOR_WHITE, 6'd0,
               hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd10, 8'd10, 3'd6, 6'd0, hppe_pkg::PAL_CLEAR);
      send_req(hppe_pkg::CMD_PLOT, 9'd511, 8'd255, 3'd7, 6'd63, PAL_TOGGLE_ALT);
      send_req(hppe_pkg::CMD_READ, 9'd511, 8'd255, hppe_pkg::COLOR_BLACK, 6'd63,
               hppe_pkg::PAL_CLEAR);

      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i == RANDOM_REQS / 2) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         send_random_req();
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);

      $display("Covered %0d plot, %0d read, %0d palette and %0d seam requests,",
               cmd_count[hppe_pkg::CMD_PLOT], cmd_count[hppe_pkg::CMD_READ],
               cmd_count[hppe_pkg::CMD_PALETTE], cmd_count[hppe_pkg::CMD_SEAM]);
      $display("including range rejects, unchanged bytes and bursty/stalled traffic.");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timeout waiting for requests or responses");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
rtl/hppe_pkg.sv
rtl/hppe_front.sv
rtl/hppe_queue.sv
rtl/hppe_back.sv
rtl/hires_pixel_plot_engine_top.sv
tb/hppe_checker.sv
tb/tb.sv
